// File: hw/rtl/hdv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML dimension value parser package
// Shared types: transaction payloads, character classes, queue entries and
// the power-of-ten table that is used to scale fraction digits.
// ----------------------------------------------------------------------------
package hdv_pkg;

  localparam int CP_W   = 21;
  localparam int INT_OW = 32;
  localparam int FRAC_W = 20;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            end_of_text;
  } char_t;

  typedef struct packed {
    logic              ok;
    logic              kind;
    logic [INT_OW-1:0] integer_part;
    logic [FRAC_W-1:0] fraction_part;
    logic              saturated;
  } result_t;

  typedef enum logic [2:0] {
    CL_SPACE   = 3'd0,
    CL_PLUS    = 3'd1,
    CL_ZERO    = 3'd2,
    CL_NZDIGIT = 3'd3,
    CL_DOT     = 3'd4,
    CL_PERCENT = 3'd5,
    CL_OTHER   = 3'd6,
    CL_END     = 3'd7
  } char_class_t;

  typedef struct packed {
    char_class_t cls;
    logic [3:0]  digit;
  } qentry_t;

  localparam logic [CP_W-1:0] CH_TAB     = CP_W'(32'h09);
  localparam logic [CP_W-1:0] CH_LF      = CP_W'(32'h0A);
  localparam logic [CP_W-1:0] CH_FF      = CP_W'(32'h0C);
  localparam logic [CP_W-1:0] CH_CR      = CP_W'(32'h0D);
  localparam logic [CP_W-1:0] CH_SPACE   = CP_W'(32'h20);
  localparam logic [CP_W-1:0] CH_PLUS    = CP_W'(32'h2B);
  localparam logic [CP_W-1:0] CH_DOT     = CP_W'(32'h2E);
  localparam logic [CP_W-1:0] CH_PERCENT = CP_W'(32'h25);
  localparam logic [CP_W-1:0] CH_ZERO    = CP_W'(32'h30);
  localparam logic [CP_W-1:0] CH_NINE    = CP_W'(32'h39);

  // Powers of ten reduced modulo 2**FRAC_W; only the low bits of the
  // fraction ever reach the result.
  localparam logic [FRAC_W-1:0] POW10_LO [10] = '{
    20'd1, 20'd10, 20'd100, 20'd1000, 20'd10000, 20'd100000,
    20'd1000000, 20'd562816, 20'd385280, 20'd707072
  };

endpackage : hdv_pkg
`default_nettype wire

// File: hw/rtl/hdv_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML dimension value parser front end
// Classifies each incoming character and extracts its digit value.
// ----------------------------------------------------------------------------
module hdv_front
  import hdv_pkg::*;
(
  input  var char_t   item,
  output qentry_t     entry
);

  always_comb begin
    entry.digit = item.code_point[3:0];
    if (item.end_of_text) begin
      entry.cls = CL_END;
    end else if (item.code_point == CH_TAB || item.code_point == CH_LF ||
                 item.code_point == CH_FF || item.code_point == CH_CR ||
                 item.code_point == CH_SPACE) begin
      entry.cls = CL_SPACE;
    end else if (item.code_point == CH_PLUS) begin
      entry.cls = CL_PLUS;
    end else if (item.code_point == CH_ZERO) begin
      entry.cls = CL_ZERO;
    end else if (item.code_point > CH_ZERO && item.code_point <= CH_NINE) begin
      entry.cls = CL_NZDIGIT;
    end else if (item.code_point == CH_DOT) begin
      entry.cls = CL_DOT;
    end else if (item.code_point == CH_PERCENT) begin
      entry.cls = CL_PERCENT;
    end else begin
      entry.cls = CL_OTHER;
    end
  end

endmodule : hdv_front
`default_nettype wire

// File: hw/rtl/hdv_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML dimension value parser queue
// Two-entry queue of classified characters between front and back end.
// ----------------------------------------------------------------------------
module hdv_queue
  import hdv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  var qentry_t push_data,
  output logic      full,
  output logic      head_valid,
  output qentry_t   head,
  input  wire logic pop
);

  qentry_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule : hdv_queue
`default_nettype wire

// File: hw/rtl/hdv_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML dimension value parser back end
// Runs the parse state machine on classified characters, accumulates the
// integer and fraction values and holds the result in an output register.
// ----------------------------------------------------------------------------
module hdv_back
  import hdv_pkg::*;
#(
  parameter int INT_WIDTH   = 32,
  parameter int FRAC_DIGITS = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  var qentry_t head,
  output logic      pop,
  output logic      result_valid,
  input  wire logic result_stall,
  output result_t   result_item
);

  localparam int CW = $clog2(FRAC_DIGITS + 1);

  typedef enum logic [5:0] {
    PH_WS    = 6'b000001,
    PH_ZEROS = 6'b000010,
    PH_INT   = 6'b000100,
    PH_DOT   = 6'b001000,
    PH_FRAC  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_t;

  phase_t                 phase, phase_next;
  logic [INT_WIDTH-1:0]   int_accum, int_accum_next;
  logic                   int_overflow, int_overflow_next;
  logic [FRAC_W-1:0]      frac_accum, frac_accum_next;
  logic [CW-1:0]          frac_count, frac_count_next;
  logic                   is_percent, is_percent_next;
  logic                   failed, failed_next;

  logic                   out_free;
  logic                   emit;
  logic [INT_WIDTH+3:0]   int_wide;
  logic                   int_sat;
  logic [3:0]             frac_idx;
  logic [FRAC_W+3:0]      frac_term;
  logic                   digit_any;
  logic                   ok;
  logic [63:0]            int_ext;

  assign out_free  = !result_valid || !result_stall;
  assign pop       = head_valid && (head.cls != CL_END || out_free);
  assign emit      = pop && head.cls == CL_END;
  assign digit_any = (head.cls == CL_ZERO) || (head.cls == CL_NZDIGIT);

  assign int_wide = ({4'd0, int_accum} << 3) + ({4'd0, int_accum} << 1)
                  + (INT_WIDTH+4)'(head.digit);
  assign int_sat  = int_overflow || (int_wide[INT_WIDTH+3:INT_WIDTH] != 4'd0);

  assign frac_idx  = (phase == PH_DOT) ? 4'(FRAC_DIGITS - 1)
                                       : 4'(FRAC_DIGITS - 1) - 4'(frac_count);
  assign frac_term = POW10_LO[frac_idx] * head.digit;

  assign ok = !failed && (phase == PH_INT || phase == PH_DOT ||
                          phase == PH_FRAC || phase == PH_DONE);
  assign int_ext = 64'(int_accum);

  always_comb begin
    phase_next        = phase;
    int_accum_next    = int_accum;
    int_overflow_next = int_overflow;
    frac_accum_next   = frac_accum;
    frac_count_next   = frac_count;
    is_percent_next   = is_percent;
    failed_next       = failed;
    if (emit) begin
      phase_next        = PH_WS;
      int_accum_next    = '0;
      int_overflow_next = 1'b0;
      frac_accum_next   = '0;
      frac_count_next   = '0;
      is_percent_next   = 1'b0;
      failed_next       = 1'b0;
    end else if (pop && !failed) begin
      unique case (phase)
        PH_WS, PH_ZEROS: begin
          if (head.cls == CL_SPACE && phase == PH_WS) begin
            phase_next = PH_WS;
          end else if (head.cls == CL_ZERO ||
                       (head.cls == CL_PLUS && phase == PH_WS)) begin
            phase_next = PH_ZEROS;
          end else if (head.cls == CL_NZDIGIT) begin
            int_accum_next    = int_sat ? '1 : int_wide[INT_WIDTH-1:0];
            int_overflow_next = int_sat;
            phase_next        = PH_INT;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_INT: begin
          if (digit_any) begin
            int_accum_next    = int_sat ? '1 : int_wide[INT_WIDTH-1:0];
            int_overflow_next = int_sat;
          end else if (head.cls == CL_DOT) begin
            phase_next = PH_DOT;
          end else begin
            is_percent_next = (head.cls == CL_PERCENT);
            phase_next      = PH_DONE;
          end
        end
        PH_DOT: begin
          if (digit_any) begin
            frac_accum_next = frac_term[FRAC_W-1:0];
            frac_count_next = CW'(1);
            phase_next      = PH_FRAC;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (digit_any) begin
            if (frac_count < CW'(FRAC_DIGITS)) begin
              frac_accum_next = frac_accum + frac_term[FRAC_W-1:0];
              frac_count_next = frac_count + CW'(1);
            end
          end else begin
            is_percent_next = (head.cls == CL_PERCENT);
            phase_next      = PH_DONE;
          end
        end
        PH_DONE: begin
          phase_next = PH_DONE;
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WS;
      int_accum    <= '0;
      int_overflow <= 1'b0;
      frac_accum   <= '0;
      frac_count   <= '0;
      is_percent   <= 1'b0;
      failed       <= 1'b0;
    end else begin
      phase        <= phase_next;
      int_accum    <= int_accum_next;
      int_overflow <= int_overflow_next;
      frac_accum   <= frac_accum_next;
      frac_count   <= frac_count_next;
      is_percent   <= is_percent_next;
      failed       <= failed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result_item.ok            <= ok;
      result_item.kind          <= ok && is_percent;
      result_item.integer_part  <= ok ? int_ext[INT_OW-1:0] : '0;
      result_item.fraction_part <= ok ? frac_accum : '0;
      result_item.saturated     <= ok && int_overflow;
    end
  end

endmodule : hdv_back
`default_nettype wire

// File: hw/rtl/html_dimension_value_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// HTML dimension value parser
// Parses a stream of code points into an HTML dimension: integer part,
// fraction part, percentage or length, and a saturation flag.
// ----------------------------------------------------------------------------
//  Channel  Handshake                  Payload      Per transaction
//  char     char_valid / char_stall    char_item    one code point or end mark
//  result   result_valid / result_stall result_item one result per end mark
//
//  One character is taken per cycle while char_stall is low; the back end's
//  parse state machine retires one queue entry per cycle and is the loop that
//  sets the rate. A result appears in the cycle after its end mark leaves the
//  queue. Reset clears the queue, the parse state and result_valid. A stalled
//  result holds back an end mark and what is queued behind it.
// ----------------------------------------------------------------------------
module html_dimension_value_parser
  import hdv_pkg::*;
#(
  parameter int INT_WIDTH   = 32,
  parameter int FRAC_DIGITS = 6
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic char_valid,
  output logic      char_stall,
  input  var char_t char_item,
  output logic      result_valid,
  input  wire logic result_stall,
  output result_t   result_item
);

  qentry_t classified;
  qentry_t head;
  logic    head_valid;
  logic    pop;
  logic    full;

  hdv_front u_front (
    .item  (char_item),
    .entry (classified)
  );

  hdv_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (char_valid),
    .push_data  (classified),
    .full       (full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  assign char_stall = full;

  hdv_back #(
    .INT_WIDTH   (INT_WIDTH),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule : html_dimension_value_parser
`default_nettype wire
